// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LVD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LVD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/lvd_pkg.sv
// Package for the log-domain Viterbi path decoder: types, codes, saturation.
// Used by lvd_score_unit and log_viterbi_path_decoder.
`timescale 1ns / 1ps
package lvd_pkg;
    localparam int MAX_STATES    = 4;
    localparam int STATE_BITS    = 2;
    localparam int SCORE_BITS    = 24;
    localparam int DEF_MAX_STEPS = 2048;
    localparam int BP_BITS       = MAX_STATES * STATE_BITS;

    localparam logic [1:0] ACT_COST = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    typedef logic signed [SCORE_BITS-1:0] t_score;

    typedef struct packed {
        logic                  load_lkl;
        logic                  acs_init;
        logic                  acs_step;
        logic                  add_lkl;
        logic                  take_max;
        logic                  sub_max;
        logic [STATE_BITS-1:0] p;
        logic [2:0]            n;
    } t_score_ctl;

    function automatic t_score sat_add(input t_score a, input t_score b, input logic sub);
        logic [SCORE_BITS:0] s;
        s = sub ? ({a[SCORE_BITS-1], a} - {b[SCORE_BITS-1], b})
                : ({a[SCORE_BITS-1], a} + {b[SCORE_BITS-1], b});
        if (s[SCORE_BITS] != s[SCORE_BITS-1]) begin
            return s[SCORE_BITS] ? {1'b1, {(SCORE_BITS-1){1'b0}}}
                                 : {1'b0, {(SCORE_BITS-1){1'b1}}};
        end
        return t_score'(s[SCORE_BITS-1:0]);
    endfunction
endpackage

// File: rtl/lvd_score_unit.sv
// Score lanes: cost table, state scores, add-compare-select per previous state.
// Depends on lvd_pkg.
`timescale 1ns / 1ps
module lvd_score_unit import lvd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_score_ctl            i_ctl,
    input  logic                  i_cost_we,
    input  logic [STATE_BITS-1:0] i_cost_from,
    input  logic [STATE_BITS-1:0] i_cost_to,
    input  t_score                i_cost_value,
    input  t_score                i_lkl [MAX_STATES],
    output logic [BP_BITS-1:0]    o_bp,
    output logic [STATE_BITS-1:0] o_best
);
    t_score                r_cost  [MAX_STATES][MAX_STATES];
    t_score                r_score [MAX_STATES];
    t_score                r_nw    [MAX_STATES];
    logic [STATE_BITS-1:0] r_bp    [MAX_STATES];
    t_score                r_mx;
    t_score                cand    [MAX_STATES];
    t_score                mx_c;
    t_score                best_s;

    always_comb begin
        for (int i = 0; i < MAX_STATES; i++) begin
            cand[i] = sat_add(r_score[i_ctl.p], r_cost[i_ctl.p][i], 1'b0);
            o_bp[i*STATE_BITS +: STATE_BITS] = r_bp[i];
        end
    end

    always_comb begin
        mx_c   = r_nw[0];
        best_s = r_score[0];
        o_best = '0;
        for (int i = 1; i < MAX_STATES; i++) begin
            if (3'(i) < i_ctl.n && r_nw[i] > mx_c) mx_c = r_nw[i];
            if (3'(i) < i_ctl.n && r_score[i] > best_s) begin
                best_s = r_score[i];
                o_best = STATE_BITS'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int f = 0; f < MAX_STATES; f++) begin
                r_score[f] <= '0;
                for (int t = 0; t < MAX_STATES; t++) r_cost[f][t] <= '0;
            end
        end else begin
            if (i_cost_we) r_cost[i_cost_from][i_cost_to] <= i_cost_value;
            for (int i = 0; i < MAX_STATES; i++) begin
                if (3'(i) < i_ctl.n) begin
                    if (i_ctl.load_lkl) r_score[i] <= i_lkl[i];
                    if (i_ctl.sub_max) r_score[i] <= sat_add(r_nw[i], r_mx, 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take_max) r_mx <= mx_c;
        for (int i = 0; i < MAX_STATES; i++) begin
            if (i_ctl.acs_init) begin
                r_nw[i] <= r_score[i];
                r_bp[i] <= STATE_BITS'(i);
            end else if (3'(i) < i_ctl.n) begin
                if (i_ctl.acs_step && cand[i] > r_nw[i]) begin
                    r_nw[i] <= cand[i];
                    r_bp[i] <= i_ctl.p;
                end
                if (i_ctl.add_lkl) r_nw[i] <= sat_add(r_nw[i], i_lkl[i], 1'b0);
            end
        end
    end
endmodule

// File: rtl/log_viterbi_path_decoder.sv
// Top level of the log-domain Viterbi path decoder: sequencer and path memories.
// Depends on lvd_pkg, lvd_score_unit and assert_macros.svh.
//
// channel   | signals                                  | handshake
// ----------+------------------------------------------+-----------------------
// command   | i_action .. i_read_index                 | start && !busy
// result    | o_path_state .. o_valid_res              | o_res_valid, 1 cycle
// config    | i_cfg_wdata (num_states)                 | i_cfg_we
//
// A cost write and the first step of a sequence are taken on accept. A later step runs
// accept, one add-compare-select pass per previous state, add, max and rescale. A final
// step then finds the best state and traces back through the stored steps, paced by the
// backpointer memory read. A path read passes the path memory and the result register.
// Synchronous reset clears scores, cost table and counters; memories are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module log_viterbi_path_decoder import lvd_pkg::*; #(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_wdata,
    input  logic [1:0]               i_action,
    input  logic [1:0]               i_from_state,
    input  logic [1:0]               i_to_state,
    input  logic signed [23:0]       i_cost_value,
    input  logic signed [23:0]       i_lkl_state0,
    input  logic signed [23:0]       i_lkl_state1,
    input  logic signed [23:0]       i_lkl_state2,
    input  logic signed [23:0]       i_lkl_state3,
    input  logic                     i_final_step,
    input  logic [10:0]              i_read_index,
    output logic                     o_res_valid,
    output logic [1:0]               o_path_state,
    output logic [10:0]              o_transitions,
    output logic [11:0]              o_path_length,
    output logic                     o_valid_res
);
    localparam int AW = $clog2(MAX_STEPS);
    localparam int CW = $clog2(MAX_STEPS + 1);
    localparam int WW = (CW > 11) ? CW : 11;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ACS  = 8'b0000_0010,
        S_ADD  = 8'b0000_0100,
        S_MAX  = 8'b0000_1000,
        S_SUB  = 8'b0001_0000,
        S_BEST = 8'b0010_0000,
        S_TB   = 8'b0100_0000,
        S_RD   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    logic [2:0]            r_cfg;
    logic [CW-1:0]         r_step_cnt;
    logic [CW-1:0]         r_len;
    logic [CW-1:0]         r_trans;
    logic [CW-1:0]         r_tr_run;
    logic [CW-1:0]         r_t;
    logic                  r_ovf;
    logic                  r_fin;
    logic [STATE_BITS-1:0] r_p;
    logic [STATE_BITS-1:0] r_cur;
    logic [STATE_BITS-1:0] r_best;
    logic                  r_rd_ok;
    t_score                r_lkl [MAX_STATES];
    logic                  r_res_stb;
    logic [1:0]            r_o_state;
    logic [10:0]           r_o_trans;
    logic [11:0]           r_o_len;
    logic                  r_o_ok;

    logic [BP_BITS-1:0]    bp_mem   [MAX_STEPS];
    logic [STATE_BITS-1:0] path_mem [MAX_STEPS];
    logic [BP_BITS-1:0]    r_bp_rd;
    logic [STATE_BITS-1:0] r_path_rd;

    t_score_ctl            ctl;
    t_score                lkl_sel [MAX_STATES];
    t_score                in_lkl  [MAX_STATES];
    logic [BP_BITS-1:0]    bp_word;
    logic [STATE_BITS-1:0] best;
    logic [2:0]            n_used;
    logic                  acc;
    logic                  bp_we, bp_re, path_we, path_re;
    logic [AW-1:0]         bp_raddr, path_waddr, path_raddr;
    logic [STATE_BITS-1:0] path_wdata, prv;
    logic [WW-1:0]         idx_w;

    assign busy   = (r_state != S_IDLE);
    assign acc    = start && !busy;
    assign n_used = (r_cfg == 3'd0) ? 3'd1 :
                    (r_cfg > 3'(MAX_STATES)) ? 3'(MAX_STATES) : r_cfg;
    assign idx_w  = WW'(i_read_index);
    assign prv    = r_bp_rd[{r_cur, 1'b0} +: STATE_BITS];

    assign in_lkl[0] = i_lkl_state0;
    assign in_lkl[1] = i_lkl_state1;
    assign in_lkl[2] = i_lkl_state2;
    assign in_lkl[3] = i_lkl_state3;

    always_comb begin
        for (int i = 0; i < MAX_STATES; i++) begin
            lkl_sel[i] = (r_state == S_IDLE) ? in_lkl[i] : r_lkl[i];
        end
        ctl          = '0;
        ctl.p        = r_p;
        ctl.n        = n_used;
        ctl.load_lkl = acc && i_action == ACT_STEP && r_step_cnt == '0;
        ctl.acs_init = acc && i_action == ACT_STEP && r_step_cnt != '0
                       && r_step_cnt < CW'(MAX_STEPS);
        ctl.acs_step = (r_state == S_ACS);
        ctl.add_lkl  = (r_state == S_ADD);
        ctl.take_max = (r_state == S_MAX);
        ctl.sub_max  = (r_state == S_SUB);
    end

    lvd_score_unit u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_cost_we    (acc && i_action == ACT_COST),
        .i_cost_from  (i_from_state),
        .i_cost_to    (i_to_state),
        .i_cost_value (i_cost_value),
        .i_lkl        (lkl_sel),
        .o_bp         (bp_word),
        .o_best       (best)
    );

    assign bp_we      = (r_state == S_SUB);
    assign bp_re      = (r_state == S_BEST) || (r_state == S_TB);
    assign bp_raddr   = (r_state == S_BEST) ? AW'(r_step_cnt - CW'(2)) : AW'(r_t - CW'(2));
    assign path_we    = (r_state == S_BEST) || (r_state == S_TB);
    assign path_waddr = (r_state == S_BEST) ? AW'(r_step_cnt - CW'(1)) : AW'(r_t - CW'(1));
    assign path_wdata = (r_state == S_BEST) ? best : prv;
    assign path_re    = acc && i_action == ACT_READ;
    assign path_raddr = idx_w[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (bp_we) bp_mem[AW'(r_step_cnt - CW'(1))] <= bp_word;
        if (bp_re) r_bp_rd <= bp_mem[bp_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (path_we) path_mem[path_waddr] <= path_wdata;
        if (path_re) r_path_rd <= path_mem[path_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg      <= 3'd3;
            r_step_cnt <= '0;
            r_len      <= '0;
            r_trans    <= '0;
            r_ovf      <= 1'b0;
            r_res_stb  <= 1'b0;
        end else begin
            r_res_stb <= 1'b0;
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (acc && i_action == ACT_STEP) begin
                        if (r_step_cnt == '0) begin
                            r_ovf      <= 1'b0;
                            r_step_cnt <= CW'(1);
                            if (i_final_step) r_state <= S_BEST;
                        end else if (r_step_cnt >= CW'(MAX_STEPS)) begin
                            r_ovf <= 1'b1;
                            if (i_final_step) r_state <= S_BEST;
                        end else begin
                            r_state <= S_ACS;
                        end
                    end else if (acc && i_action == ACT_READ) begin
                        r_state <= S_RD;
                    end
                end
                S_ACS: begin
                    if ({1'b0, r_p} == n_used - 3'd1) r_state <= S_ADD;
                end
                S_ADD: r_state <= S_MAX;
                S_MAX: r_state <= S_SUB;
                S_SUB: begin
                    r_step_cnt <= r_step_cnt + CW'(1);
                    r_state    <= r_fin ? S_BEST : S_IDLE;
                end
                S_BEST: begin
                    if (r_step_cnt == CW'(1)) begin
                        r_len      <= r_step_cnt;
                        r_trans    <= '0;
                        r_step_cnt <= '0;
                        r_res_stb  <= 1'b1;
                        r_state    <= S_IDLE;
                    end else begin
                        r_state <= S_TB;
                    end
                end
                S_TB: begin
                    if (r_t == CW'(1)) begin
                        r_len      <= r_step_cnt;
                        r_trans    <= r_tr_run + CW'(prv != r_cur);
                        r_step_cnt <= '0;
                        r_res_stb  <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_res_stb <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_p     <= '0;
                r_rd_ok <= idx_w < WW'(r_len);
                if (acc) begin
                    r_fin <= i_final_step;
                    for (int i = 0; i < MAX_STATES; i++) r_lkl[i] <= in_lkl[i];
                end
            end
            S_ACS: r_p <= r_p + STATE_BITS'(1);
            S_BEST: begin
                r_best    <= best;
                r_cur     <= best;
                r_t       <= r_step_cnt - CW'(1);
                r_tr_run  <= '0;
                r_o_state <= best;
                r_o_len   <= 12'(r_step_cnt);
                r_o_trans <= '0;
                r_o_ok    <= !r_ovf;
            end
            S_TB: begin
                r_cur     <= prv;
                r_t       <= r_t - CW'(1);
                r_tr_run  <= r_tr_run + CW'(prv != r_cur);
                r_o_state <= r_best;
                r_o_len   <= 12'(r_step_cnt);
                r_o_trans <= 11'(r_tr_run + CW'(prv != r_cur));
                r_o_ok    <= !r_ovf;
            end
            S_RD: begin
                r_o_state <= r_rd_ok ? r_path_rd : 2'd0;
                r_o_trans <= 11'(r_trans);
                r_o_len   <= 12'(r_len);
                r_o_ok    <= r_rd_ok && !r_ovf;
            end
            default: ;
        endcase
    end

    assign o_res_valid   = r_res_stb;
    assign o_path_state  = r_o_state;
    assign o_transitions = r_o_trans;
    assign o_path_length = r_o_len;
    assign o_valid_res   = r_o_ok;

    `LVD_ASSERT(a_res_idle, i_clk, i_rst_n, o_res_valid |-> !busy, "result while busy")
    `LVD_ASSERT(a_step_cap, i_clk, i_rst_n, r_step_cnt <= CW'(MAX_STEPS), "step count overrun")
    `LVD_ASSERT(a_tb_idx, i_clk, i_rst_n, (r_state == S_TB) |-> (r_t != '0), "traceback index zero")
    `LVD_ASSERT(a_read_seq, i_clk, i_rst_n, (acc && i_action == ACT_READ) |=> (r_state == S_RD), "read not taken")
endmodule
